// ===== sv/imu_bab_pkg.sv =====
// Shared types and constants for the IMU block-average bias estimator.
package imu_bab_pkg;

  localparam int AXES = 6;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic add;
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

// ===== sv/imu_block_average_bias_top.sv =====
// IMU block-average bias estimator: six lane accumulators with serial dividers.
//
// Input words arrive on s_axis, one six-axis IMU sample per word. Each axis is
// added to its running sum and the sample count is advanced. When the count
// reaches the window set by cfg_wr_data (0 acts as 1, values above MAX_WINDOW
// act as MAX_WINDOW), one word with the rounded mean of every axis leaves on
// m_axis and the sums and count are cleared.
// A sample that does not complete a window leaves s_axis_tready high on the
// next cycle. A sample that completes a window holds s_axis_tready low while
// the block forms the rounded magnitudes (S_PREP), runs the six restoring
// dividers side by side, each producing one quotient bit per cycle (S_DIV),
// and loads the output register (S_OUT). The result word is valid, and
// s_axis_tready high again, on the cycle after the output register loads.
// The result sits in an output register; further samples are accepted while
// it waits, but the next completed window stalls in its last step until the
// receiver has taken the previous word.
// Reset clears the sums, the count and the output valid flag, and sets the
// window to 1024 samples.
module imu_block_average_bias_top
  import imu_bab_pkg::*;
#(
  parameter int MAX_WINDOW = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, zero fill
  input  logic [((AXES*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // bias_accel_x, bias_accel_y, bias_accel_z, bias_gyro_x, bias_gyro_y, bias_gyro_z, zero fill
  output logic [((AXES*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int DATA_W = ((AXES*SAMPLE_WIDTH+7)/8)*8;
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int STEP_W = $clog2(SUM_W);

  state_t state, state_next;
  lane_ctrl_t ctrl;
  logic [CFG_W-1:0]  window_cfg;
  logic [CNT_W-1:0]  window;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              emit;
  logic              out_load;
  logic              can_load;
  logic [AXES-1:0][SAMPLE_WIDTH-1:0] quotient;
  logic [AXES-1:0]   neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      window_cfg <= cfg_wr_data;
    end
  end

  always_comb begin
    if (window_cfg == '0) begin
      window = CNT_W'(1);
    end else if (int'(window_cfg) > MAX_WINDOW) begin
      window = CNT_W'(MAX_WINDOW);
    end else begin
      window = CNT_W'(window_cfg);
    end
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign count_inc = count + CNT_W'(1);
  assign emit      = (count_inc >= window);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_inc;
      end else if (state == S_PREP) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      divisor <= count_inc;
    end
    if (state == S_PREP) begin
      step <= '0;
    end else if (state == S_DIV) begin
      step <= step + STEP_W'(1);
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    ctrl          = '0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.add      = s_axis_tvalid;
        if (s_axis_tvalid && emit) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctrl.load  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctrl.step = 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // A pending word must be taken before the new means overwrite it.
        if (can_load) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    imu_bab_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
    ) u_lane (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .sample(s_axis_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
      .divisor(divisor),
      .quotient(quotient[i]),
      .neg(neg[i])
    );
  end

  imu_bab_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DATA_W(DATA_W)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .load(out_load),
    .quotient(quotient),
    .neg(neg),
    .can_load(can_load),
    .tvalid(m_axis_tvalid),
    .tready(m_axis_tready),
    .tdata(m_axis_tdata)
  );

endmodule

// ===== sv/imu_bab_lane.sv =====
// One axis lane: running sum, rounding offset and a one-bit-per-cycle divider.
module imu_bab_lane
  import imu_bab_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_W = 26,
  parameter int CNT_W = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctrl_t              ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [CNT_W-1:0]        divisor,
  output logic [SAMPLE_WIDTH-1:0] quotient,
  output logic                    neg
);

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] dvd;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   trial;
  logic             fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.add) begin
      sum <= sum + SUM_W'(sample);
    end else if (ctrl.load) begin
      sum <= '0;
    end
  end

  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial = {rem, dvd[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= sum[SUM_W-1];
      dvd <= mag + SUM_W'(divisor >> 1);
      rem <= '0;
    end else if (ctrl.step) begin
      dvd <= {dvd[SUM_W-2:0], fits};
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
    end
  end

  assign quotient = dvd[SAMPLE_WIDTH-1:0];

endmodule

// ===== sv/imu_bab_merge.sv =====
// Merging stage: restores the signs of the lane results and holds the output word.
module imu_bab_merge
  import imu_bab_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DATA_W = 96
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [AXES-1:0][SAMPLE_WIDTH-1:0]  quotient,
  input  logic [AXES-1:0]                    neg,
  output logic                               can_load,
  output logic                               tvalid,
  input  logic                               tready,
  output logic [DATA_W-1:0]                  tdata
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = '0;
    for (int i = 0; i < AXES; i++) begin
      data_next[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = neg[i] ? SAMPLE_WIDTH'(-quotient[i])
                                                         : quotient[i];
    end
  end

  assign can_load = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= data_next;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the IMU block-average bias estimator.
module tb_top
  import imu_bab_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int DATA_W = ((AXES*SAMPLE_WIDTH+7)/8)*8;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1500;
  localparam int REPORT_MAX = 10;

  typedef logic [AXES-1:0][SAMPLE_WIDTH-1:0] imu_word_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_EXTREME,
    MIX_BIASED,
    MIX_SATURATE
  } sample_mix_t;

  typedef struct {
    bit        wr;
    logic [CFG_W-1:0] win;
    imu_word_t smp;
    bit        typed;
    imu_word_t mean;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  imu_block_average_bias_top #(
    .MAX_WINDOW(MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: running sums, sample count and the window register.
  longint axis_sum [AXES];
  int sample_cnt = 0;
  logic [CFG_W-1:0] window_reg = CFG_RESET;

  imu_word_t bias_q [$];
  dir_row_t dir_rows [$];

  string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

  int err_cnt = 0;
  int reported = 0;
  int samples_in = 0;
  int bias_out = 0;
  int window_writes = 0;
  int rand_items = 0;
  int idle_cnt = 0;

  // Sender burst control.
  bit tx_gaps = 1'b1;
  int burst_left = 0;

  // Receiver pattern and long hold-off.
  int pressure_seq = 0;
  int pressure_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_tick = 0;

  // Per-phase shaping of random samples.
  int bias_base [AXES];
  bit axis_neg [AXES];

  function automatic imu_word_t axes6(input int a0, input int a1, input int a2,
                                      input int a3, input int a4, input int a5);
    imu_word_t r;
    r[0] = a0[15:0];
    r[1] = a1[15:0];
    r[2] = a2[15:0];
    r[3] = a3[15:0];
    r[4] = a4[15:0];
    r[5] = a5[15:0];
    return r;
  endfunction

  // Adds one sample to the sums; returns 1 with the rounded means when a window closes.
  function automatic bit step_bias(input imu_word_t smp, output imu_word_t mean);
    int w;
    longint mag;
    longint q;
    longint r;
    bit neg;
    mean = '0;
    for (int i = 0; i < AXES; i++) axis_sum[i] += longint'($signed(smp[i]));
    sample_cnt++;
    w = int'(window_reg);
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (sample_cnt < w) return 1'b0;
    for (int i = 0; i < AXES; i++) begin
      neg = axis_sum[i] < 0;
      mag = neg ? -axis_sum[i] : axis_sum[i];
      q = (mag + longint'(sample_cnt / 2)) / longint'(sample_cnt);
      r = neg ? -q : q;
      mean[i] = r[15:0];
      axis_sum[i] = 0;
    end
    sample_cnt = 0;
    return 1'b1;
  endfunction

  function automatic imu_word_t make_sample(input sample_mix_t mix);
    imu_word_t r;
    int v;
    for (int i = 0; i < AXES; i++) begin
      case (mix)
        MIX_EXTREME: begin
          case ($urandom_range(0, 4))
            0: v = 32767;
            1: v = -32768;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
        MIX_BIASED: v = bias_base[i] + int'($urandom_range(0, 128)) - 64;
        MIX_SATURATE: begin
          if ($urandom_range(0, 7) == 0) v = int'($urandom);
          else v = axis_neg[i] ? -32768 : 32767;
        end
        default: v = int'($urandom);
      endcase
      r[i] = v[15:0];
    end
    return r;
  endfunction

  task automatic add_row(input bit wr, input logic [CFG_W-1:0] win, input imu_word_t smp,
                         input bit typed, input imu_word_t mean);
    dir_row_t row;
    row.wr = wr;
    row.win = win;
    row.smp = smp;
    row.typed = typed;
    row.mean = mean;
    dir_rows.push_back(row);
  endtask

  // Offers one word and waits for it to be taken; with tx_gaps set, the sender idles between bursts.
  task automatic send_sample(input imu_word_t smp, input bit typed, input imu_word_t typed_mean);
    imu_word_t m;
    bit hit;
    s_axis_tdata <= smp;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    hit = step_bias(smp, m);
    if (typed) bias_q.push_back(typed_mean);
    else if (hit) bias_q.push_back(m);
    samples_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (tx_gaps) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(8, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // The window may only change once every pending estimate has left the block.
  task automatic set_window(input logic [CFG_W-1:0] w);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (bias_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = w;
    window_writes++;
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 150 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (pressure_seen != pressure_seq) begin
      pressure_seen <= pressure_seq;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= (rx_tick % 5 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    imu_word_t exp_w;
    imu_word_t got_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_w = m_axis_tdata;
      if (bias_q.size() == 0) begin
        err_cnt++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("bias word %0d arrived with nothing expected: %h", bias_out, got_w);
        end
      end else begin
        exp_w = bias_q.pop_front();
        for (int i = 0; i < AXES; i++) begin
          if (got_w[i] !== exp_w[i]) begin
            err_cnt++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("bias word %0d %s: expected %0d, got %0d", bias_out, axis_name[i],
                       $signed(exp_w[i]), $signed(got_w[i]));
            end
          end
        end
      end
      bias_out++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] w;
    sample_mix_t mix;
    int n;

    for (int i = 0; i < AXES; i++) axis_sum[i] = 0;

    // Window of one, then zero acting as one: every sample comes back as its own mean.
    add_row(1, 11'd1, axes6(0, 0, 0, 0, 0, 0), 1, axes6(0, 0, 0, 0, 0, 0));
    add_row(0, 11'd1, axes6(32767, 32767, 32767, 32767, 32767, 32767), 1,
            axes6(32767, 32767, 32767, 32767, 32767, 32767));
    add_row(0, 11'd1, axes6(-32768, -32768, -32768, -32768, -32768, -32768), 1,
            axes6(-32768, -32768, -32768, -32768, -32768, -32768));
    add_row(0, 11'd1, axes6(32767, -32768, 1, -1, 21845, -21846), 1,
            axes6(32767, -32768, 1, -1, 21845, -21846));
    add_row(1, 11'd0, axes6(-1, 1, -32768, 32767, 12345, -12345), 1,
            axes6(-1, 1, -32768, 32767, 12345, -12345));
    // Window of two: halves round away from zero, extremes stay in range.
    add_row(1, 11'd2, axes6(1, -1, 32767, -32768, -32768, 3), 0, '0);
    add_row(0, 11'd2, axes6(0, 0, 32767, -32768, 32767, 0), 1,
            axes6(1, -1, 32767, -32768, -1, 2));
    add_row(0, 11'd2, axes6(2, -2, 100, -100, 7, -7), 0, '0);
    add_row(0, 11'd2, axes6(1, -1, 101, -100, 0, 0), 1, axes6(2, -2, 101, -100, 4, -4));
    // Window of three: thirds round towards the nearer integer.
    add_row(1, 11'd3, axes6(1, 1, 1, -1, -1, -1), 0, '0);
    add_row(0, 11'd3, axes6(0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, 11'd3, axes6(0, 1, 2, 0, -1, -2), 1, axes6(0, 1, 1, 0, -1, -1));
    // Window shrunk part-way through: the estimate divides by the samples held.
    add_row(1, 11'd8, axes6(100, -200, 300, -400, 500, -600), 0, '0);
    add_row(0, 11'd8, axes6(101, -201, 301, -401, 501, -601), 0, '0);
    add_row(0, 11'd8, axes6(-7, 9, -32768, 32767, 3, -3), 0, '0);
    add_row(1, 11'd2, axes6(5, -5, 32767, -32768, 2, -2), 0, '0);
    add_row(0, 11'd2, axes6(6, 7, 8, 9, 10, 11), 0, '0);
    add_row(0, 11'd2, axes6(-6, -7, -8, -9, -10, -11), 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) set_window(dir_rows[i].win);
      send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].mean);
    end

    // Long hold-off on the result side while every sample completes a window.
    tx_gaps = 1'b0;
    set_window(11'd1);
    pressure_seq <= pressure_seq + 1;
    repeat (60) begin
      send_sample(make_sample(MIX_RANDOM), 0, '0);
      rand_items++;
    end

    // Largest window, driven near full scale so the sums approach their width.
    tx_gaps = 1'b1;
    for (int i = 0; i < AXES; i++) axis_neg[i] = 1'($urandom_range(0, 1));
    set_window(11'd2047);
    repeat (MAX_WINDOW + $urandom_range(0, 20)) begin
      send_sample(make_sample(MIX_SATURATE), 0, '0);
      rand_items++;
    end

    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = 11'd0;
        1: w = 11'd2047;
        2: w = 11'd1024;
        3: w = 11'd1;
        default: w = CFG_W'($urandom_range(2, 12));
      endcase
      mix = sample_mix_t'($urandom_range(0, 3));
      for (int i = 0; i < AXES; i++) begin
        bias_base[i] = int'($urandom_range(0, 60000)) - 30000;
        axis_neg[i] = 1'($urandom_range(0, 1));
      end
      tx_gaps = ($urandom_range(0, 2) != 0);
      n = $urandom_range(15, 60);
      set_window(w);
      repeat (n) begin
        send_sample(make_sample(mix), 0, '0);
        rand_items++;
      end
    end

    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (bias_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d IMU samples and checked %0d bias estimates over %0d window settings,",
             samples_in, bias_out, window_writes);
    $display("including zero, one, two, three, eight and over-range windows; %0d field errors.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== imu_block_average_bias_top.f =====
sv/imu_bab_pkg.sv
sv/imu_bab_lane.sv
sv/imu_bab_merge.sv
sv/imu_block_average_bias_top.sv
bench/tb_top.sv
